/* rtl/core/cgl_pkg.sv */
// ----------------------------------------------------------------------------
// cgl_pkg
// Shared types and constants for the limited cell gradient block.
// ----------------------------------------------------------------------------
package cgl_pkg;

  localparam int MaxFaces = 8;
  localparam int FracBits = 16;
  localparam int FaceIdxW = $clog2(MaxFaces);
  localparam int FaceCntW = $clog2(MaxFaces + 1);

  localparam logic signed [47:0] S48Max = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48Min = 48'sh8000_0000_0000;
  localparam logic signed [31:0] S32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;

  // Byte address of the boundary mode register.
  localparam logic [1:0] AddrUseBoundary = 2'b00;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ACC,
    ST_GRAD,
    ST_EXT_MUL,
    ST_EXT_SUM,
    ST_LIM_CHK,
    ST_LIM_DIV,
    ST_LIM_MUL,
    ST_DONE
  } cgl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic face_load;   // capture a face and update means
    logic mul_start;   // form phif * area products
    logic div_start;   // start the three divisions
    logic acc;         // add quotients into the sums
    logic grad;        // saturate sums into the gradient
    logic ext_mul;     // multiply gradient by one stored offset
    logic ext_sum;     // add terms and update spread
    logic lim_chk;     // compare spreads
    logic lim_div;     // start the limiter factor division
    logic lim_mul;     // scale the gradient
    logic done;        // drive result and clear cell state
  } cgl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic last;
    logic ext_last;
    logic limit;
  } cgl_stat_t;

endpackage

/* rtl/core/cgl_div.sv */
// ----------------------------------------------------------------------------
// cgl_div
// Unsigned restoring divider, one quotient bit per cycle, 64 by 64 bits.
// ----------------------------------------------------------------------------
module cgl_div import cgl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);

  logic [6:0]  count;
  logic [64:0] rem;
  logic [63:0] quo;
  logic [63:0] dsr;
  logic [64:0] trial;
  logic [64:0] shifted;

  assign shifted  = {rem[63:0], quo[63]};
  assign trial    = shifted - {1'b0, dsr};
  assign quotient = quo;

  // Control: count down 64 steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
    end else if (start) begin
      count <= 7'd64;
      busy  <= 1'b1;
    end else if (busy) begin
      count <= count - 7'd1;
      busy  <= (count != 7'd1);
    end
  end

  // One quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/core/cgl_datapath.sv */
// ----------------------------------------------------------------------------
// cgl_datapath
// Face accumulation, offset store, extrapolation and limiter arithmetic.
// ----------------------------------------------------------------------------
module cgl_datapath import cgl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cgl_cmd_t           cmd,
  output cgl_stat_t          stat,
  input  logic               use_boundary_values,
  input  logic signed [31:0] phi_cell,
  input  logic signed [31:0] phi_neighbor,
  input  logic signed [31:0] phi_boundary,
  input  logic               is_interior,
  input  logic signed [31:0] area_x,
  input  logic signed [31:0] area_y,
  input  logic signed [31:0] area_z,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  input  logic signed [31:0] offset_z,
  input  logic [30:0]        cell_volume,
  input  logic               last_face,
  output logic signed [31:0] grad_x,
  output logic signed [31:0] grad_y,
  output logic signed [31:0] grad_z,
  output logic               was_limited
);

  // Captured face.
  logic signed [31:0] phif;
  logic signed [31:0] area [3];
  logic [30:0]        vol;
  logic               last;

  // Cell state.
  logic signed [47:0] sum [3];
  logic [FaceCntW-1:0] face_count;
  logic signed [31:0] cell_value;
  logic signed [31:0] mean_min;
  logic signed [31:0] mean_max;
  logic               interior_seen;
  logic [95:0]        offset_store [MaxFaces];

  // Working registers.
  logic signed [63:0] prod [3];
  logic               neg [3];
  logic signed [31:0] g [3];
  logic [FaceCntW-1:0] ext_idx;
  logic [FaceCntW-1:0] rd_idx;
  logic [95:0]        off_rd;
  logic signed [49:0] vmin;
  logic signed [49:0] vmax;
  logic signed [49:0] s1;
  logic signed [33:0] s2;
  logic signed [33:0] mspread;
  logic               limited;

  logic [63:0] div_dd [3];
  logic        div_busy [3];
  logic [63:0] div_q [3];

  logic signed [32:0] mean_sum;
  logic signed [31:0] mean;
  logic [30:0]        vol_eff;

  assign mean_sum = 33'(phi_cell) + 33'(phi_neighbor);
  assign mean     = mean_sum[32:1];
  assign vol_eff  = (cell_volume == '0) ? 31'd1 : cell_volume;
  assign mspread  = 34'(mean_max) - 34'(mean_min);

  // Three dividers, shared by the face divisions and the limiter factor.
  for (genvar i = 0; i < 3; i++) begin : g_div
    always_comb begin
      if (cmd.lim_div) begin
        div_dd[i] = 64'(s2) << FracBits;
      end else begin
        div_dd[i] = prod[i][63] ? 64'(-prod[i]) : 64'(prod[i]);
      end
    end
    cgl_div u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (cmd.div_start | cmd.lim_div),
      .dividend (div_dd[i]),
      .divisor  (cmd.lim_div ? 64'(s1) : {33'h0, vol}),
      .busy     (div_busy[i]),
      .quotient (div_q[i])
    );
  end

  assign stat.div_busy = div_busy[0] | div_busy[1] | div_busy[2];
  assign stat.last     = last;
  assign stat.ext_last = (ext_idx == face_count - FaceCntW'(1)) || (face_count == '0);
  assign stat.limit    = limited;

  // Face capture and mean tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_min      <= S32Max;
      mean_max      <= S32Min;
      interior_seen <= 1'b0;
      face_count    <= '0;
      cell_value    <= '0;
    end else if (cmd.done) begin
      mean_min      <= S32Max;
      mean_max      <= S32Min;
      interior_seen <= 1'b0;
      face_count    <= '0;
      cell_value    <= '0;
    end else if (cmd.face_load) begin
      cell_value <= phi_cell;
      if (is_interior) begin
        interior_seen <= 1'b1;
        if (mean < mean_min) mean_min <= mean;
        if (mean > mean_max) mean_max <= mean;
      end
      if (face_count < FaceCntW'(MaxFaces)) begin
        face_count <= face_count + FaceCntW'(1);
      end
    end
  end

  // Offset store write.
  always_ff @(posedge clk) begin
    if (cmd.face_load && face_count < FaceCntW'(MaxFaces)) begin
      offset_store[face_count[FaceIdxW-1:0]] <= {offset_z, offset_y, offset_x};
    end
  end

  // Offset store read, registered. The summing step fetches the next entry
  // so that it is ready for the following multiply.
  assign rd_idx = cmd.ext_sum ? ext_idx + FaceCntW'(1) : ext_idx;

  always_ff @(posedge clk) begin
    off_rd <= offset_store[rd_idx[FaceIdxW-1:0]];
  end

  // Payload capture of one face.
  always_ff @(posedge clk) begin
    if (cmd.face_load) begin
      if (is_interior) phif <= mean;
      else if (use_boundary_values) phif <= phi_boundary;
      else phif <= phi_cell;
      area[0] <= area_x;
      area[1] <= area_y;
      area[2] <= area_z;
      vol     <= vol_eff;
      last    <= last_face;
    end
  end

  // Per-axis arithmetic.
  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [63:0] q;
    logic signed [48:0] acc_sum;
    logic signed [47:0] c48;
    logic signed [31:0] off_i;
    logic signed [31:0] gs;

    assign q     = neg[i] ? -$signed(div_q[i]) : $signed(div_q[i]);
    assign c48   = (q > 64'(S48Max)) ? S48Max : (q < 64'(S48Min)) ? S48Min : q[47:0];
    assign acc_sum = 49'(sum[i]) + 49'(c48);
    assign off_i = off_rd[32*i +: 32];
    assign gs    = (sum[i] > 48'(S32Max)) ? S32Max :
                   (sum[i] < 48'(S32Min)) ? S32Min : $signed(sum[i][31:0]);

    always_ff @(posedge clk) begin
      if (rst || cmd.done) begin
        sum[i] <= '0;
      end else if (cmd.acc) begin
        if (acc_sum > 49'(S48Max)) sum[i] <= S48Max;
        else if (acc_sum < 49'(S48Min)) sum[i] <= S48Min;
        else sum[i] <= acc_sum[47:0];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.mul_start) begin
        prod[i] <= 64'(phif) * 64'(area[i]);
      end else if (cmd.ext_mul) begin
        prod[i] <= 64'(g[i]) * 64'(off_i);
      end else if (cmd.lim_mul) begin
        prod[i] <= 64'(g[i]) * $signed({32'h0, div_q[i][31:0]});
      end
      if (cmd.div_start) neg[i] <= prod[i][63];
      if (cmd.grad) g[i] <= gs;
    end
  end

  // Extrapolated spread over stored faces.
  logic signed [49:0] v;
  logic               ext_first;
  assign v = 50'(cell_value) + 50'(prod[0] >>> FracBits)
           + 50'(prod[1] >>> FracBits) + 50'(prod[2] >>> FracBits);

  always_ff @(posedge clk) begin
    if (rst || cmd.done) begin
      ext_idx   <= '0;
      ext_first <= 1'b1;
      vmin      <= '0;
      vmax      <= '0;
    end else begin
      if (cmd.grad) begin
        ext_idx   <= '0;
        ext_first <= 1'b1;
      end
      if (cmd.ext_sum && face_count != '0) begin
        ext_idx   <= ext_idx + FaceCntW'(1);
        ext_first <= 1'b0;
        if (ext_first || v < vmin) vmin <= v;
        if (ext_first || v > vmax) vmax <= v;
      end
    end
  end

  // Limiter decision and result.
  always_ff @(posedge clk) begin
    if (rst || cmd.done) begin
      limited <= 1'b0;
    end else if (cmd.lim_chk) begin
      s1      <= vmax - vmin;
      s2      <= mspread;
      limited <= interior_seen && ((vmax - vmin) > (50'(mspread) <<< 1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      grad_x      <= limited ? 32'(prod[0] >>> FracBits) : g[0];
      grad_y      <= limited ? 32'(prod[1] >>> FracBits) : g[1];
      grad_z      <= limited ? 32'(prod[2] >>> FracBits) : g[2];
      was_limited <= limited;
    end
  end

endmodule

/* rtl/core/cgl_ctrl.sv */
// ----------------------------------------------------------------------------
// cgl_ctrl
// Sequencer for face accumulation and the end-of-cell limiter pass.
// ----------------------------------------------------------------------------
module cgl_ctrl import cgl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      strobe,
  output cgl_cmd_t  cmd,
  input  cgl_stat_t stat
);

  cgl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == ST_DONE);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (start) state_next = ST_MUL;
      ST_MUL:     state_next = ST_DIV;
      ST_DIV:     state_next = ST_ACC;
      ST_ACC:     if (!stat.div_busy) state_next = stat.last ? ST_GRAD : ST_IDLE;
      ST_GRAD:    state_next = ST_EXT_MUL;
      ST_EXT_MUL: state_next = ST_EXT_SUM;
      ST_EXT_SUM: state_next = stat.ext_last ? ST_LIM_CHK : ST_EXT_MUL;
      ST_LIM_CHK: state_next = ST_LIM_DIV;
      ST_LIM_DIV: state_next = ST_LIM_MUL;
      ST_LIM_MUL: if (!stat.div_busy) state_next = ST_DONE;
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE:    cmd.face_load = start;
      ST_MUL:     cmd.mul_start = 1'b1;
      ST_DIV:     cmd.div_start = 1'b1;
      ST_ACC:     cmd.acc = !stat.div_busy;
      ST_GRAD:    cmd.grad = 1'b1;
      ST_EXT_MUL: cmd.ext_mul = 1'b1;
      ST_EXT_SUM: cmd.ext_sum = 1'b1;
      ST_LIM_CHK: cmd.lim_chk = 1'b1;
      ST_LIM_DIV: cmd.lim_div = stat.limit;
      ST_LIM_MUL: cmd.lim_mul = !stat.div_busy && stat.limit;
      ST_DONE:    cmd.done = 1'b1;
      default:    cmd = '0;
    endcase
  end

  // The result strobe follows the final step of a cell.
  assert property (@(posedge clk) disable iff (rst) strobe |-> $past(state == ST_DONE))
    else $error("strobe without done step");
  assert property (@(posedge clk) disable iff (rst) cmd.acc |-> !stat.div_busy)
    else $error("accumulate while dividing");
  assert property (@(posedge clk) disable iff (rst) (state == ST_IDLE) |-> !cmd.done)
    else $error("done in idle");

endmodule

/* rtl/core/cell_gradient_limited_core.sv */
// ----------------------------------------------------------------------------
// cell_gradient_limited_core
// Green-Gauss cell gradient with a local-extremum limiter, Q16.16.
// ----------------------------------------------------------------------------
// Usage: present one face on the payload ports with start high while busy
// is low; the face is taken at that edge. Faces of one cell follow each
// other, the final one flagged by last_face. A face that is not the last
// keeps busy high while the 64-step bit-serial divider divides the three
// area products by the cell volume, so the next face is taken only after
// that. On a last face the block then walks the n stored offsets (at most
// eight) with a multiply step and a summing step per face. The result is
// on grad_x/y/z and was_limited with strobe high after that walk and the
// limiter check, and later still when the limiter runs the divider once
// more for its scale factor. busy is low during the
// strobe cycle, so the next cell may start then. The receiver cannot
// stall and takes the result in that one cycle. Reset clears all cell
// state and the configuration register; the offset store needs no
// clearing. use_boundary_values sits at address 0 of the APB port. The
// user must write it only while busy is low; the core does not enforce it.
// ----------------------------------------------------------------------------
module cell_gradient_limited_core import cgl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] phi_cell,
  input  logic signed [31:0] phi_neighbor,
  input  logic signed [31:0] phi_boundary,
  input  logic               is_interior,
  input  logic signed [31:0] area_x,
  input  logic signed [31:0] area_y,
  input  logic signed [31:0] area_z,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  input  logic signed [31:0] offset_z,
  input  logic [30:0]        cell_volume,
  input  logic               last_face,
  output logic               strobe,
  output logic signed [31:0] grad_x,
  output logic signed [31:0] grad_y,
  output logic signed [31:0] grad_z,
  output logic               was_limited
);

  logic      use_boundary_values;
  cgl_cmd_t  cmd;
  cgl_stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrUseBoundary) ? {31'h0, use_boundary_values} : '0;

  // Register write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      use_boundary_values <= 1'b0;
    end else if (psel && penable && pwrite && paddr == AddrUseBoundary) begin
      use_boundary_values <= pwdata[0];
    end
  end

  cgl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .cmd    (cmd),
    .stat   (stat)
  );

  cgl_datapath u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .use_boundary_values (use_boundary_values),
    .phi_cell            (phi_cell),
    .phi_neighbor        (phi_neighbor),
    .phi_boundary        (phi_boundary),
    .is_interior         (is_interior),
    .area_x              (area_x),
    .area_y              (area_y),
    .area_z              (area_z),
    .offset_x            (offset_x),
    .offset_y            (offset_y),
    .offset_z            (offset_z),
    .cell_volume         (cell_volume),
    .last_face           (last_face),
    .grad_x              (grad_x),
    .grad_y              (grad_y),
    .grad_z              (grad_z),
    .was_limited         (was_limited)
  );

endmodule

/* tb/sv/cgl_checker.sv */
// ----------------------------------------------------------------------------
// cgl_checker
// Watches the face and result transfers of the limited cell gradient core.
// It predicts each cell gradient and compares it with the core's output.
// ----------------------------------------------------------------------------
module cgl_checker import cgl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] phi_cell,
  input  logic signed [31:0] phi_neighbor,
  input  logic signed [31:0] phi_boundary,
  input  logic               is_interior,
  input  logic signed [31:0] area_x,
  input  logic signed [31:0] area_y,
  input  logic signed [31:0] area_z,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  input  logic signed [31:0] offset_z,
  input  logic [30:0]        cell_volume,
  input  logic               last_face,
  input  logic               strobe,
  input  logic signed [31:0] grad_x,
  input  logic signed [31:0] grad_y,
  input  logic signed [31:0] grad_z,
  input  logic               was_limited,
  output int                 fail_count,
  output int                 pending,
  output int                 grads_seen,
  output int                 limited_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
    logic               lim;
  } grad_res_t;

  grad_res_t grad_q[$];

  // Predictor copy of the configuration and per-cell state.
  logic           boundary_mode;
  longint         acc_sum [3];
  longint         off_mem [MaxFaces][3];
  int             n_faces;
  longint         last_phi;
  longint         lo_mean;
  longint         hi_mean;
  logic           any_interior;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic clear_cell_state();
    for (int i = 0; i < 3; i++) acc_sum[i] = 0;
    n_faces      = 0;
    last_phi     = 0;
    lo_mean      = longint'(S32Max);
    hi_mean      = longint'(S32Min);
    any_interior = 1'b0;
  endtask

  // Accumulate one face; on the last face push the expected gradient.
  task automatic predict_face();
    longint    area [3];
    longint    offs [3];
    longint    g [3];
    longint    phif, vol, c, v, vmin, vmax, s1, s2, fv;
    grad_res_t r;
    area[0] = area_x;   area[1] = area_y;   area[2] = area_z;
    offs[0] = offset_x; offs[1] = offset_y; offs[2] = offset_z;
    vol = (cell_volume == 0) ? 64'sd1 : longint'({33'd0, cell_volume});
    last_phi = phi_cell;
    if (is_interior) begin
      phif = (longint'(phi_cell) + longint'(phi_neighbor)) >>> 1;
      if (phif < lo_mean) lo_mean = phif;
      if (phif > hi_mean) hi_mean = phif;
      any_interior = 1'b1;
    end else begin
      phif = boundary_mode ? longint'(phi_boundary) : longint'(phi_cell);
    end
    for (int i = 0; i < 3; i++) begin
      c = clamp((phif * area[i]) / vol, longint'(S48Min), longint'(S48Max));
      acc_sum[i] = clamp(acc_sum[i] + c, longint'(S48Min), longint'(S48Max));
    end
    if (n_faces < MaxFaces) begin
      for (int i = 0; i < 3; i++) off_mem[n_faces][i] = offs[i];
      n_faces++;
    end
    if (!last_face) return;

    for (int i = 0; i < 3; i++) g[i] = clamp(acc_sum[i], longint'(S32Min), longint'(S32Max));
    // Spread of the face values extrapolated from the unlimited gradient.
    vmin = 0;
    vmax = 0;
    for (int k = 0; k < n_faces; k++) begin
      v = last_phi;
      for (int i = 0; i < 3; i++) v += (g[i] * off_mem[k][i]) >>> FracBits;
      if (k == 0 || v < vmin) vmin = v;
      if (k == 0 || v > vmax) vmax = v;
    end
    s1 = vmax - vmin;
    r.lim = 1'b0;
    if (any_interior) begin
      s2 = hi_mean - lo_mean;
      if (s1 > 2 * s2) begin
        fv = (s2 <<< FracBits) / s1;
        for (int i = 0; i < 3; i++) g[i] = (g[i] * fv) >>> FracBits;
        r.lim = 1'b1;
      end
    end
    r.gx = 32'(clamp(g[0], longint'(S32Min), longint'(S32Max)));
    r.gy = 32'(clamp(g[1], longint'(S32Min), longint'(S32Max)));
    r.gz = 32'(clamp(g[2], longint'(S32Min), longint'(S32Max)));
    grad_q.push_back(r);
    clear_cell_state();
  endtask

  // Compare one result transfer with the oldest expected gradient.
  task automatic compare_grad();
    grad_res_t e;
    if (grad_q.size() == 0) begin
      $display("%0t: unexpected result gx=%0d gy=%0d gz=%0d lim=%0b",
               $time, grad_x, grad_y, grad_z, was_limited);
      fail_count++;
      return;
    end
    e = grad_q.pop_front();
    if (grad_x !== e.gx || grad_y !== e.gy || grad_z !== e.gz ||
        was_limited !== e.lim) begin
      $display("%0t: gradient mismatch: expected %0d %0d %0d lim=%0b, got %0d %0d %0d lim=%0b",
               $time, e.gx, e.gy, e.gz, e.lim, grad_x, grad_y, grad_z, was_limited);
      fail_count++;
    end
    grads_seen++;
    if (was_limited === 1'b1) limited_seen++;
  endtask

  initial begin
    fail_count   = 0;
    grads_seen   = 0;
    limited_seen = 0;
    boundary_mode = 1'b0;
    clear_cell_state();
  end

  // Sample every channel at the rising edge, before the testbench drives.
  always @(posedge clk) begin
    if (rst) begin
      boundary_mode = 1'b0;
      clear_cell_state();
      grad_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == AddrUseBoundary)
        boundary_mode = pwdata[0];
      if (strobe) compare_grad();
      if (start && !busy) predict_face();
    end
    pending = grad_q.size();
  end

endmodule

/* tb/sv/tb_cell_gradient_limited_core.sv */
// ----------------------------------------------------------------------------
// tb_cell_gradient_limited_core
// Drives faces and register writes into the limited cell gradient core.
// Directed cells cover extremes, zero volume, equal means and face overflow;
// random cells follow in four phases with different sender gaps and modes.
// ----------------------------------------------------------------------------
module tb_cell_gradient_limited_core;
  import cgl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1_000_000;
  localparam int FacesPerPhase = 350;

  typedef struct {
    logic signed [31:0] pc, pn, pb;
    logic               interior;
    logic signed [31:0] ax, ay, az;
    logic signed [31:0] ox, oy, oz;
    logic [30:0]        vol;
    logic               last;
  } face_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] phi_cell = '0, phi_neighbor = '0, phi_boundary = '0;
  logic               is_interior = 1'b0;
  logic signed [31:0] area_x = '0, area_y = '0, area_z = '0;
  logic signed [31:0] offset_x = '0, offset_y = '0, offset_z = '0;
  logic [30:0]        cell_volume = '0;
  logic               last_face = 1'b0;
  logic               strobe;
  logic signed [31:0] grad_x, grad_y, grad_z;
  logic               was_limited;

  int fail_count, pending, grads_seen, limited_seen;
  int faces_sent = 0;
  int idle_pct = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  cell_gradient_limited_core uut (.*);

  cgl_checker chk (.*);

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // One APB write: setup cycle, then access cycle.
  task automatic reg_write(input logic [1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Present one face and hold it until the transfer completes.
  task automatic send_face(input face_t f);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    phi_cell <= f.pc;   phi_neighbor <= f.pn;   phi_boundary <= f.pb;
    is_interior <= f.interior;
    area_x <= f.ax;     area_y <= f.ay;         area_z <= f.az;
    offset_x <= f.ox;   offset_y <= f.oy;       offset_z <= f.oz;
    cell_volume <= f.vol;
    last_face <= f.last;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    faces_sent++;
  endtask

  // Wait for every expected gradient, then let the core settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly small values so limiting happens; sometimes full range or extremes.
  function automatic logic signed [31:0] rand_val(input int big_pct);
    int m;
    m = $urandom_range(0, 99);
    if (m < 5) begin
      case ($urandom_range(0, 3))
        0: return S32Max;
        1: return S32Min;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if (m < 5 + big_pct) return $urandom;
    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  function automatic logic [30:0] rand_vol();
    case ($urandom_range(0, 9))
      0: return 31'($urandom_range(0, 3));
      1: return 31'($urandom);
      default: return 31'($urandom_range(32'h0000_4000, 32'h0004_0000));
    endcase
  endfunction

  function automatic face_t rand_face(input logic [30:0] vol, input int big_pct);
    face_t f;
    f.pc = rand_val(big_pct);  f.pn = rand_val(big_pct);  f.pb = rand_val(big_pct);
    f.interior = ($urandom_range(0, 3) != 0);
    f.ax = rand_val(big_pct);  f.ay = rand_val(big_pct);  f.az = rand_val(big_pct);
    f.ox = rand_val(big_pct);  f.oy = rand_val(big_pct);  f.oz = rand_val(big_pct);
    f.vol = vol;
    f.last = 1'b0;
    return f;
  endfunction

  // One random cell: a run of faces sharing a volume and, for most faces, a cell value.
  task automatic rand_cell();
    face_t f;
    int n, big;
    logic [30:0] vol;
    logic signed [31:0] pc;
    n   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
    big = ($urandom_range(0, 4) == 0) ? 60 : 10;
    vol = rand_vol();
    pc  = rand_val(big);
    for (int k = 0; k < n; k++) begin
      f = rand_face(vol, big);
      if ($urandom_range(0, 9) != 0) f.pc = pc;
      f.last = (k == n - 1);
      send_face(f);
    end
  endtask

  task automatic directed_cells();
    face_t f;
    // Single boundary face at the field extremes with the smallest volume.
    f = '{S32Max, S32Min, S32Min, 1'b0, S32Max, S32Min, S32Max,
          S32Min, S32Max, S32Min, 31'd1, 1'b1};
    send_face(f);
    // Zero volume is treated as one.
    f = '{S32Min, S32Max, S32Max, 1'b1, S32Min, S32Max, -32'sd1,
          S32Max, S32Min, 32'sd0, 31'd0, 1'b1};
    send_face(f);
    // Equal interior means plus a steep boundary face: gradient limited to zero.
    f = '{32'sh0001_0000, 32'sh0001_0000, 32'sh0050_0000, 1'b1, 32'sh0001_0000, 32'sd0,
          32'sd0, 32'sh0001_0000, 32'sd0, 32'sd0, 31'h0001_0000, 1'b0};
    send_face(f);
    f.interior = 1'b0;
    f.ax = -32'sh0001_0000;
    f.ox = -32'sh0001_0000;
    f.pb = -32'sh0050_0000;
    send_face(f);
    f.interior = 1'b1;
    f.ax = 32'sh0000_8000;
    f.ay = 32'sh0002_0000;
    f.last = 1'b1;
    send_face(f);
    // Eleven faces: the last three exceed the offset store.
    for (int k = 0; k < 11; k++) begin
      f = rand_face(31'h0001_0000, 20);
      f.interior = k[0];
      f.last = (k == 10);
      send_face(f);
    end
    // Interior faces with the largest mean spread, largest volume.
    f = '{S32Max, S32Max, 32'sd0, 1'b1, 32'sh0000_0100, 32'sd0, 32'sd0,
          32'sd0, 32'sd0, 32'sd0, 31'h7FFF_FFFF, 1'b0};
    send_face(f);
    f.pc = S32Min;
    f.pn = S32Min;
    f.last = 1'b1;
    send_face(f);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cells in both boundary modes.
    reg_write(AddrUseBoundary, 32'd1);
    directed_cells();
    drain();
    reg_write(AddrUseBoundary, 32'd0);
    directed_cells();
    drain();

    // Random phases: sender gap rate and boundary mode change between them.
    for (int p = 0; p < 4; p++) begin
      int goal;
      case (p)
        0: idle_pct = 0;
        1: idle_pct = 51;
        2: idle_pct = 15;
        default: idle_pct = 0;
      endcase
      reg_write(AddrUseBoundary, p[0] ? 32'hFFFF_FFFF : 32'hFFFF_FFFE);
      goal = faces_sent + FacesPerPhase;
      while (faces_sent < goal) rand_cell();
      drain();
    end

    repeat (200) @(posedge clk);
    $display("Sent %0d faces over both boundary modes; %0d cell gradients checked.",
             faces_sent, grads_seen);
    $display("The limiter engaged on %0d cells.", limited_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
